[hw/rtl/tccs_pkg.sv]
// tccs_pkg: shared types and constants of the text console engine
// request and result structs, queue entry, back-end state and status types
// no dependencies
package tccs_pkg;

  // character codes and reset contents
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  BLANK_CODE   = 8'd32;
  localparam logic [7:0]  RESET_COLOR  = 8'h0F;
  localparam logic [15:0] RESET_CELL   = {RESET_COLOR, BLANK_CODE};

  // decoupling queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // configuration port: one register at byte address 0, word index in paddr[2]
  localparam int         APB_ADDR_W     = 3;
  localparam logic       REG_TEXT_COLOR = 1'b0;

  // one input request
  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } res_t;

  // request class decided by the front end
  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_READ_OOR
  } op_kind_t;

  // queue entry
  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // back-end sequencer
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RADDR,
    BK_RDATA,
    BK_BLANK
  } bk_state_t;

  typedef struct packed {
    logic clearing;
    logic blanking;
  } bk_status_t;

endpackage

[hw/rtl/tccs_front.sv]
// tccs_front: accepts requests and classifies them for the back end
// depends on tccs_pkg
module tccs_front import tccs_pkg::*; #(
  parameter int CELL_COUNT = 2000
) (
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_t      cmd,
  input  q_status_t q_status,
  output logic      push,
  output op_t       op
);

  // stall only while the queue is full
  assign cmd_stall = q_status.full;
  assign push      = cmd_valid && !q_status.full;

  // classify: put, newline, in-range read, out-of-range read
  always_comb begin
    op.char_code  = cmd.char_code;
    op.read_index = cmd.read_index;
    case (cmd.mode)
      1'b1: begin
        if (32'(cmd.read_index) < 32'(CELL_COUNT)) begin
          op.kind = OP_READ;
        end else begin
          op.kind = OP_READ_OOR;
        end
      end
      default: begin
        if (cmd.char_code == NEWLINE_CODE) begin
          op.kind = OP_NEWLINE;
        end else begin
          op.kind = OP_PUT;
        end
      end
    endcase
  end

endmodule

[hw/rtl/tccs_queue.sv]
// tccs_queue: short fifo of classified requests between front and back end
// depends on tccs_pkg
module tccs_queue import tccs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       head,
  output q_status_t status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LastSlot = PW'(QUEUE_DEPTH - 1);

  op_t           slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

[hw/rtl/tccs_back.sv]
// tccs_back: carries out queued requests on the screen memory and cursor
// screen is a ring of rows; a scroll moves the top-row offset and blanks one row
// depends on tccs_pkg
module tccs_back import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_color,
  input  q_status_t  q_status,
  input  op_t        op,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res,
  output bk_status_t status
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int XW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam logic [XW-1:0] LastCol  = XW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
  localparam logic [AW-1:0] LastCell = AW'(CELL_COUNT - 1);
  localparam logic [AW:0]   CellsW   = (AW + 1)'(CELL_COUNT);
  localparam logic [AW:0]   RowStep  = (AW + 1)'(COLUMNS);

  bk_state_t     state, state_next;
  logic [XW-1:0] cursor_x, cursor_x_next;
  logic [RW-1:0] cursor_y, cursor_y_next;
  logic [AW-1:0] row_base, row_base_next;   // physical start of the cursor row
  logic [AW-1:0] top_base, top_base_next;   // physical start of screen row 0
  logic [AW-1:0] sweep_addr, sweep_addr_next;
  logic [XW-1:0] blank_col, blank_col_next;
  logic [AW-1:0] rd_addr, rd_addr_next;
  logic [15:0]   rd_data;
  logic          res_valid_next;
  logic          res_load;
  logic [15:0]   res_cell;
  logic          res_scrolled;
  logic          new_line;
  logic          res_free;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem [CELL_COUNT];

  // step a row start by one row around the ring
  function automatic logic [AW-1:0] next_row(input logic [AW-1:0] a);
    logic [AW:0] s;
    s = {1'b0, a} + RowStep;
    return (s >= CellsW) ? AW'(s - CellsW) : AW'(s);
  endfunction

  // screen index to physical address
  function automatic logic [AW-1:0] phys_index(input logic [10:0] idx,
                                              input logic [AW-1:0] base);
    logic [AW:0] s;
    s = (AW + 1)'(idx) + {1'b0, base};
    return (s >= CellsW) ? AW'(s - CellsW) : AW'(s);
  endfunction

  assign res_free        = !res_valid || !res_stall;
  assign status.clearing = (state == BK_CLEAR);
  assign status.blanking = (state == BK_BLANK);

  // sequencer: next state, memory write, cursor update
  always_comb begin
    state_next      = state;
    pop             = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = row_base + AW'(cursor_x);
    mem_wdata       = {text_color, op.char_code};
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    row_base_next   = row_base;
    top_base_next   = top_base;
    sweep_addr_next = sweep_addr;
    blank_col_next  = blank_col;
    rd_addr_next    = rd_addr;
    res_load        = 1'b0;
    res_cell        = '0;
    res_scrolled    = 1'b0;
    new_line        = 1'b0;
    case (state)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = RESET_CELL;
        if (sweep_addr == LastCell) begin
          sweep_addr_next = '0;
          state_next      = BK_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_status.empty && res_free) begin
          pop = 1'b1;
          case (op.kind)
            OP_PUT: begin
              mem_we = 1'b1;
              if (cursor_x == LastCol) begin
                new_line = 1'b1;
              end else begin
                cursor_x_next = cursor_x + 1'b1;
                res_load      = 1'b1;
              end
            end
            OP_NEWLINE: begin
              new_line = 1'b1;
            end
            OP_READ: begin
              rd_addr_next = phys_index(op.read_index, top_base);
              state_next   = BK_RADDR;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
          // move to the start of the next row, scrolling from the last row
          if (new_line) begin
            cursor_x_next = '0;
            row_base_next = next_row(row_base);
            if (cursor_y == LastRow) begin
              top_base_next  = next_row(top_base);
              blank_col_next = '0;
              state_next     = BK_BLANK;
            end else begin
              cursor_y_next = cursor_y + 1'b1;
              res_load      = 1'b1;
            end
          end
        end
      end
      BK_RADDR: begin
        state_next = BK_RDATA;
      end
      BK_RDATA: begin
        res_cell   = rd_data;
        res_load   = 1'b1;
        state_next = BK_IDLE;
      end
      BK_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = row_base + AW'(blank_col);
        mem_wdata = {text_color, BLANK_CODE};
        if (blank_col == LastCol) begin
          res_scrolled = 1'b1;
          res_load     = 1'b1;
          state_next   = BK_IDLE;
        end else begin
          blank_col_next = blank_col + 1'b1;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    res_valid_next = res_load || (res_valid && res_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      cursor_x   <= '0;
      cursor_y   <= '0;
      row_base   <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      blank_col  <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      row_base   <= row_base_next;
      top_base   <= top_base_next;
      sweep_addr <= sweep_addr_next;
      blank_col  <= blank_col_next;
      res_valid  <= res_valid_next;
    end
  end

  // read address and result payload
  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    if (res_load) begin
      res.cell_value    <= res_cell;
      res.cursor_column <= 7'(cursor_x_next);
      res.cursor_row    <= 5'(cursor_y_next);
      res.scrolled      <= res_scrolled;
    end
  end

  // screen memory: one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // screen memory: registered read port
  always_ff @(posedge clk) begin
    if (state == BK_RADDR) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/text_console_cursor_scroll.sv]
// text_console_cursor_scroll: text console with cursor, wrap and scroll
// throughput: one put or newline per cycle while the result output is not stalled;
// a read (address and data states, registered memory read port) or a scroll (the new
// row is blanked) holds the back end, which takes no new request until it is through
// reset: cursor at row 0 column 0, color 0x0F; a clearing pass blanks the screen
// memory, requests queue but run only after it
module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] text_color;
  logic       cfg_write;
  logic       push;
  logic       pop;
  op_t        push_op;
  op_t        head;
  q_status_t  q_status;
  bk_status_t bk_status;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR);
  assign prdata    = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_write) begin
      text_color <= pwdata[7:0];
    end
  end

  // front end
  tccs_front #(
    .CELL_COUNT(COLUMNS * ROWS)
  ) u_front (
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .q_status (q_status),
    .push     (push),
    .op       (push_op)
  );

  // request queue
  tccs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  // back end
  tccs_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .text_color(text_color),
    .q_status  (q_status),
    .op        (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .status    (bk_status)
  );

  // checks
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    bk_status.clearing |-> !res_valid)
    else $error("result during clearing pass");

  a_no_result_in_blank: assert property (@(posedge clk) disable iff (rst)
    bk_status.blanking |-> !res_valid)
    else $error("result while blanking a row");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.scrolled) |->
      (res.cursor_column == 7'd0 && res.cursor_row == 5'(ROWS - 1)))
    else $error("scroll left cursor off the last row start");

  a_color_write: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (text_color == $past(pwdata[7:0])))
    else $error("text color not updated");

endmodule
